// ----- src/euclidean_distance_3d_top_macros.svh -----
// Assertion macros for the 3D distance pipeline.
// Expects clk and arst_n in the scope of every use.
`ifndef EUCLIDEAN_DISTANCE_3D_TOP_MACROS_SVH
`define EUCLIDEAN_DISTANCE_3D_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ED3D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ED3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ed3d_pkg.sv -----
// Shared constants for the 3D distance pipeline.
// No dependencies.
package ed3d_pkg;

	localparam int ED3D_COORD_BITS_DEF = 32;

endpackage

// ----- src/ed3d_diff.sv -----
// Stage 1: absolute coordinate differences of two signed points.
// Depends on ed3d_pkg.
module ed3d_diff import ed3d_pkg::*; #(
	parameter int COORD_BITS = ED3D_COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vld_i,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	output logic                         vld_o,
	output logic [COORD_BITS-1:0]        dx_o,
	output logic [COORD_BITS-1:0]        dy_o,
	output logic [COORD_BITS-1:0]        dz_o
);

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic [COORD_BITS:0] dab;
		logic [COORD_BITS:0] dba;
		dab = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		dba = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
		return dab[COORD_BITS] ? dba[COORD_BITS-1:0] : dab[COORD_BITS-1:0];
	endfunction

	logic                  vld_s1;
	logic [COORD_BITS-1:0] dx_s1;
	logic [COORD_BITS-1:0] dy_s1;
	logic [COORD_BITS-1:0] dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= abs_diff(first_x, second_x);
			dy_s1 <= abs_diff(first_y, second_y);
			dz_s1 <= abs_diff(first_z, second_z);
		end
	end

	assign vld_o = vld_s1;
	assign dx_o  = dx_s1;
	assign dy_o  = dy_s1;
	assign dz_o  = dz_s1;

endmodule

// ----- src/ed3d_square.sv -----
// Stages 2 to 4: split squaring of three magnitudes and sum of squares.
// Depends on ed3d_pkg.
module ed3d_square import ed3d_pkg::*; #(
	parameter int COORD_BITS = ED3D_COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      vld_i,
	input  logic [COORD_BITS-1:0]     dx_i,
	input  logic [COORD_BITS-1:0]     dy_i,
	input  logic [COORD_BITS-1:0]     dz_i,
	output logic                      vld_o,
	output logic [2*COORD_BITS+1:0]   sum_o
);

	localparam int H   = (COORD_BITS + 1) / 2;
	localparam int L   = COORD_BITS - H;
	localparam int SQW = 2 * COORD_BITS;
	localparam int SW  = 2 * COORD_BITS + 2;

	logic [COORD_BITS-1:0] d [3];

	logic             vld_s2;
	logic [2*H-1:0]   pll_s2 [3];
	logic [H+L-1:0]   plh_s2 [3];
	logic [2*L-1:0]   phh_s2 [3];

	logic             vld_s3;
	logic [SQW-1:0]   sq_s3 [3];

	logic             vld_s4;
	logic [SW-1:0]    sum_s4;

	assign d[0] = dx_i;
	assign d[1] = dy_i;
	assign d[2] = dz_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_i;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		always_ff @(posedge clk) begin
			if (adv) begin
				pll_s2[a] <= (2*H)'(d[a][H-1:0]) * (2*H)'(d[a][H-1:0]);
				plh_s2[a] <= (H+L)'(d[a][H-1:0]) * (H+L)'(d[a][COORD_BITS-1:H]);
				phh_s2[a] <= (2*L)'(d[a][COORD_BITS-1:H]) * (2*L)'(d[a][COORD_BITS-1:H]);
				sq_s3[a]  <= {phh_s2[a], {(2*H){1'b0}}}
					+ (SQW'(plh_s2[a]) << (H + 1))
					+ SQW'(pll_s2[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
		end
	end

	assign vld_o = vld_s4;
	assign sum_o = sum_s4;

endmodule

// ----- src/ed3d_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on ed3d_pkg.
module ed3d_sqrt import ed3d_pkg::*; #(
	parameter int COORD_BITS = ED3D_COORD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      vld_i,
	input  logic [2*COORD_BITS+1:0]   rad_i,
	output logic                      vld_o,
	output logic [COORD_BITS:0]       root_o
);

	localparam int R = COORD_BITS + 1;
	localparam int W = 2 * COORD_BITS + 2;

	logic         vld_s  [R];
	logic [R+1:0] rem_s  [R];
	logic [R-1:0] root_s [R];
	logic [W-1:0] rad_s  [R];

	assign vld_s[0]  = vld_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad_i;

	for (genvar j = 0; j < R; j++) begin : g_step
		localparam int I = R - 1 - j;

		logic [R+3:0] sh;
		logic [R+3:0] tr;
		logic         ge;
		logic [R-1:0] root_n;

		assign sh     = {rem_s[j], rad_s[j][2*I+1 -: 2]};
		assign tr     = {2'b00, root_s[j], 2'b01};
		assign ge     = sh >= tr;
		assign root_n = {root_s[j][R-2:0], ge};

		if (j < R - 1) begin : g_mid
			logic [R+3:0] df;
			logic [R+1:0] rem_n;

			assign df    = sh - tr;
			assign rem_n = ge ? df[R+1:0] : sh[R+1:0];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j+1] <= 1'b0;
				end else if (adv) begin
					vld_s[j+1] <= vld_s[j];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[j+1]  <= rem_n;
					root_s[j+1] <= root_n;
					rad_s[j+1]  <= rad_s[j];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_o <= 1'b0;
				end else if (adv) begin
					vld_o <= vld_s[j];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					root_o <= root_n;
				end
			end
		end
	end

endmodule

// ----- src/euclidean_distance_3d_top.sv -----
// Euclidean distance between two signed fixed-point 3D points, floor of the root.
// Throughput: one transaction per cycle; the pipeline halts as a whole on dist_stall.
// Depth set by the root unit, one result bit per stage, after diff/square/sum stages.
// Reset: arst_n clears all valid bits at once; no clearing pass, no stored state.
// Depends on ed3d_pkg, ed3d_diff, ed3d_square, ed3d_sqrt and the assertion macros.
`include "euclidean_distance_3d_top_macros.svh"

module euclidean_distance_3d_top import ed3d_pkg::*; #(
	parameter int COORD_BITS = ED3D_COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pt_valid,
	output logic                         pt_stall,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	output logic                         dist_valid,
	input  logic                         dist_stall,
	output logic [COORD_BITS:0]          dist_res
);

	localparam int LAT   = COORD_BITS + 5;
	localparam int CNT_W = $clog2(LAT + 1);

	logic                    adv;
	logic                    vld_d;
	logic [COORD_BITS-1:0]   dx;
	logic [COORD_BITS-1:0]   dy;
	logic [COORD_BITS-1:0]   dz;
	logic                    vld_q;
	logic [2*COORD_BITS+1:0] sum;
	logic                    in_acc;
	logic                    out_acc;
	logic [CNT_W-1:0]        cnt_q;

	assign adv      = !(dist_valid && dist_stall);
	assign pt_stall = !adv;
	assign in_acc   = pt_valid && !pt_stall;
	assign out_acc  = dist_valid && !dist_stall;

	ed3d_diff #(
		.COORD_BITS(COORD_BITS)
	) u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.vld_i    (pt_valid),
		.first_x  (first_x),
		.first_y  (first_y),
		.first_z  (first_z),
		.second_x (second_x),
		.second_y (second_y),
		.second_z (second_z),
		.vld_o    (vld_d),
		.dx_o     (dx),
		.dy_o     (dy),
		.dz_o     (dz)
	);

	ed3d_square #(
		.COORD_BITS(COORD_BITS)
	) u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (vld_d),
		.dx_i   (dx),
		.dy_i   (dy),
		.dz_i   (dz),
		.vld_o  (vld_q),
		.sum_o  (sum)
	);

	ed3d_sqrt #(
		.COORD_BITS(COORD_BITS)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_i  (vld_q),
		.rad_i  (sum),
		.vld_o  (dist_valid),
		.root_o (dist_res)
	);

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	`ED3D_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(LAT), "too many transactions in flight")
	`ED3D_ASSERT_NOW(a_no_invent, dist_valid, cnt_q != '0, "result without a transaction")
	`ED3D_ASSERT_NEXT(a_stall_hold, dist_valid && dist_stall, cnt_q == $past(cnt_q), "count moved while stalled")

endmodule

// ----- tb/tb_euclidean_distance_3d_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for euclidean_distance_3d_top: point pairs in, floor distances out.
// Predicts each distance with exact wide arithmetic, with bursty input and stalled output.
// Depends on ed3d_pkg and the euclidean_distance_3d_top RTL.
module tb_euclidean_distance_3d_top import ed3d_pkg::*;;

	localparam int CB = ED3D_COORD_BITS_DEF;
	localparam int SUM_W = 2 * CB + 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PAIRS = 1450;
	localparam int DRAIN_CYCLES = CB + 45;
	localparam int HOLD_CYCLES = 240;
	localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
	localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] C_ZERO = '0;
	localparam logic [CB-1:0] C_NEG1 = '1;
	localparam logic [CB-1:0] C_LSB = 1;
	localparam logic [CB-1:0] C_UNIT = 1 << 16;

	typedef struct packed {
		logic [CB-1:0] first_x;
		logic [CB-1:0] first_y;
		logic [CB-1:0] first_z;
		logic [CB-1:0] second_x;
		logic [CB-1:0] second_y;
		logic [CB-1:0] second_z;
	} point_pair_t;

	logic clk;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	logic [CB-1:0] first_x = '0;
	logic [CB-1:0] first_y = '0;
	logic [CB-1:0] first_z = '0;
	logic [CB-1:0] second_x = '0;
	logic [CB-1:0] second_y = '0;
	logic [CB-1:0] second_z = '0;
	logic dist_valid;
	logic dist_stall = 1'b0;
	logic [CB:0] dist_res;

	point_pair_t pair_q[$];
	logic [CB:0] dist_expected[$];
	point_pair_t next_pair;
	logic pt_fired = 1'b0;
	int pts_accepted = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;
	int rx_cycles = 0;
	int hold_left = 0;
	int holds_done = 0;

	euclidean_distance_3d_top #(.COORD_BITS(CB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.first_x   (first_x),
		.first_y   (first_y),
		.first_z   (first_z),
		.second_x  (second_x),
		.second_y  (second_y),
		.second_z  (second_z),
		.dist_valid(dist_valid),
		.dist_stall(dist_stall),
		.dist_res  (dist_res)
	);

	function automatic logic [SUM_W-1:0] coord_gap(logic [CB-1:0] a, logic [CB-1:0] b);
		logic signed [CB:0] d;
		logic [SUM_W-1:0] mag;
		d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
		mag = d[CB] ? {{(SUM_W-CB-1){1'b0}}, -d} : {{(SUM_W-CB-1){1'b0}}, d};
		return mag;
	endfunction

	function automatic logic [CB:0] distance_floor(point_pair_t p);
		logic [SUM_W-1:0] dx;
		logic [SUM_W-1:0] dy;
		logic [SUM_W-1:0] dz;
		logic [SUM_W-1:0] sq_sum;
		logic [SUM_W-1:0] root;
		logic [SUM_W-1:0] cand;
		dx = coord_gap(p.first_x, p.second_x);
		dy = coord_gap(p.first_y, p.second_y);
		dz = coord_gap(p.first_z, p.second_z);
		sq_sum = dx * dx + dy * dy + dz * dz;
		root = '0;
		for (int i = CB + 1; i >= 0; i--) begin
			cand = root;
			cand[i] = 1'b1;
			if (cand * cand <= sq_sum)
				root = cand;
		end
		return root[CB:0];
	endfunction

	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return C_MIN;
			1: return C_MAX;
			2: return C_ZERO;
			3: return C_NEG1;
			4: return CB'($urandom_range(0, 1 << 20)) - CB'(1 << 19);
			default: return CB'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [CB-1:0] nudge(logic [CB-1:0] c);
		return c + CB'($urandom_range(0, 1 << 13)) - CB'(1 << 12);
	endfunction

	task automatic add_pair(logic [CB-1:0] ax, logic [CB-1:0] ay, logic [CB-1:0] az,
			logic [CB-1:0] bx, logic [CB-1:0] by, logic [CB-1:0] bz);
		point_pair_t p;
		p.first_x = ax;
		p.first_y = ay;
		p.first_z = az;
		p.second_x = bx;
		p.second_y = by;
		p.second_z = bz;
		pair_q.push_back(p);
	endtask

	task automatic add_random_pair();
		logic [CB-1:0] ax;
		logic [CB-1:0] ay;
		logic [CB-1:0] az;
		ax = pick_coord();
		ay = pick_coord();
		az = pick_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: add_pair(ax, ay, az, pick_coord(), pick_coord(), pick_coord());
			4, 5, 6: add_pair(ax, ay, az, nudge(ax), nudge(ay), nudge(az));
			7: add_pair(ax, ay, az, ax, ay, az);
			8: add_pair(ax, ay, az, ax, pick_coord(), az);
			default: add_pair(ax, ay, az, ~ax, ~ay, ~az);
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		logic [CB-1:0] rx;
		logic [CB-1:0] ry;
		logic [CB-1:0] rz;
		rx = CB'($urandom());
		ry = CB'($urandom());
		rz = CB'($urandom());
		add_pair(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		add_pair(rx, ry, rz, rx, ry, rz);
		add_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		add_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		add_pair(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
		add_pair(C_MIN, C_ZERO, C_ZERO, C_MAX, C_ZERO, C_ZERO);
		add_pair(C_ZERO, C_MIN, C_ZERO, C_ZERO, C_MAX, C_ZERO);
		add_pair(C_ZERO, C_ZERO, C_MIN, C_ZERO, C_ZERO, C_MAX);
		add_pair(C_NEG1, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		add_pair(C_ZERO, C_NEG1, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		add_pair(C_ZERO, C_ZERO, C_NEG1, C_ZERO, C_ZERO, C_ZERO);
		add_pair(C_LSB, C_LSB, C_LSB, C_ZERO, C_ZERO, C_ZERO);
		add_pair(C_UNIT, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		add_pair(3 * C_UNIT, 4 * C_UNIT, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
		add_pair(-2 * C_UNIT, C_ZERO, 2 * C_UNIT, C_UNIT, 4 * C_UNIT, -10 * C_UNIT);
		add_pair(C_MIN, C_MIN, C_MIN, C_ZERO, C_ZERO, C_ZERO);
		add_pair(C_MAX, C_MAX, C_MAX, C_NEG1, C_NEG1, C_NEG1);
		add_pair(C_MIN, C_MAX, C_NEG1, C_MIN, C_MAX, C_NEG1);
		for (int n = 0; n < RANDOM_PAIRS; n++)
			add_random_pair();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pair_q.size() > 0 || pt_valid)
			@(posedge clk);
		while (dist_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && dist_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// point-pair driver: bursts of transactions with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
		end else if (!pt_valid || pt_fired) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pt_valid <= 1'b0;
			end else if (pair_q.size() > 0) begin
				next_pair = pair_q.pop_front();
				first_x <= next_pair.first_x;
				first_y <= next_pair.first_y;
				first_z <= next_pair.first_z;
				second_x <= next_pair.second_x;
				second_y <= next_pair.second_y;
				second_z <= next_pair.second_z;
				pt_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pt_valid <= 1'b0;
			end
		end
	end

	// result receiver: stall pattern switches mode now and then, plus long hold-offs
	always @(negedge clk) begin
		rx_cycles <= rx_cycles + 1;
		if (rx_mode_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_mode_left <= $urandom_range(32, 400);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dist_stall <= 1'b1;
		end else if (holds_done < 2 && pts_accepted >= 400 + holds_done * 600) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			dist_stall <= 1'b1;
		end else begin
			case (rx_mode)
				0: dist_stall <= 1'b0;
				1: dist_stall <= 1'($urandom_range(0, 1));
				2: dist_stall <= (rx_cycles % 7) < 3;
				default: dist_stall <= $urandom_range(0, 9) != 0;
			endcase
		end
	end

	// input and output monitor
	always @(posedge clk) begin
		logic [CB:0] want;
		point_pair_t seen;
		if (arst_n) begin
			pt_fired <= pt_valid && !pt_stall;
			if (pt_valid && !pt_stall) begin
				seen = {first_x, first_y, first_z, second_x, second_y, second_z};
				dist_expected.push_back(distance_floor(seen));
				pts_accepted++;
			end
			if (dist_valid && !dist_stall) begin
				if (dist_expected.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected dist_res, expected none, actual %0d",
						$time, dist_res);
				end else begin
					want = dist_expected.pop_front();
					if (dist_res !== want) begin
						mismatches++;
						$display("%0t: dist_res mismatch, expected %0d, actual %0d",
							$time, want, dist_res);
					end
				end
			end
		end else begin
			pt_fired <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
